// File: src/text_console_cell_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_cell_writer_assert.svh
// Assertion macros shared by the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw_checker: property failed");

// Next-cycle implication, disabled during reset.
`define TCW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw_checker: property failed");

`endif

// File: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int KIND_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int CELL_W     = 16;
  localparam int COLOR_W    = 3;
  localparam int MEM_ADDR_W = 15;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CELL_W-1:0] WHITE_BLANK  = 16'h0720;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REG_TEXT_COLOR  = 1'b0,
    REG_TEXT_BRIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    kind_t               kind;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  cursor_pos;
    logic [CELL_W-1:0]   cell_value;
    logic                fault;
  } result_t;

  typedef struct packed {
    logic                  en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [CELL_W-1:0]     data;
  } ram_wr_t;

  typedef struct packed {
    logic                  en;
    logic [MEM_ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_READ_WAIT,
    ST_BS_READ,
    ST_BS_CHECK,
    ST_REM_WAIT,
    ST_TAB_FILL,
    ST_SCROLL,
    ST_DONE
  } state_t;

endpackage

// File: src/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram import tcw_pkg::*; #(
  parameter int DEPTH = 2000
) (
  input  logic              clk,
  input  ram_wr_t           wr,
  input  ram_rd_t           rd,
  output logic [CELL_W-1:0] rdata
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr[ADDR_W-1:0]];
    end
  end

endmodule

// File: src/tcw_rem.sv
// ----------------------------------------------------------------------------
// tcw_rem
// Remainder by a constant divisor: reciprocal multiply, then subtract.
// ----------------------------------------------------------------------------
module tcw_rem #(
  parameter int DIVIDEND_W = 11,
  parameter int DIVISOR    = 80
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] remainder
);

  localparam int SHIFT  = DIVIDEND_W + $clog2(DIVISOR);
  localparam int MULT_W = DIVIDEND_W + 2;
  localparam int PROD_W = SHIFT + DIVIDEND_W;
  localparam longint unsigned MULT_VAL =
    ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
  localparam logic [MULT_W-1:0]     MULT  = MULT_W'(MULT_VAL);
  localparam logic [DIVIDEND_W-1:0] DIV_C = DIVIDEND_W'(DIVISOR);

  logic [DIVIDEND_W-1:0] x_q;
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] quot;
  logic                  stage1;
  logic                  stage2;

  // quotient is exact for every dividend below 2**DIVIDEND_W
  assign quot = prod[SHIFT +: DIVIDEND_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
    if (start) begin
      x_q <= dividend;
    end
    if (stage1) begin
      prod <= PROD_W'(x_q) * PROD_W'(MULT);
    end
    if (stage2) begin
      remainder <= x_q - quot * DIV_C;
    end
  end

endmodule

// File: src/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console: ROWS x COLUMNS cell store with cursor, put/clear/read items.
// ----------------------------------------------------------------------------
// Items enter on item/item_valid/item_stall and each produces one transfer on
// result/result_valid/result_stall. A transfer happens on a rising edge with
// valid high and stall low. One item is worked at a time; item_stall is low
// only while the block is idle, and a finished result waits in the output
// register so the next item can enter while the receiver stalls.
// Clear and scroll (on newline or wrap) handle one cell per cycle, scroll
// reading through the read port and writing through the write port of the
// cell memory; backspace scans back over blank cells, and a tab fills
// white blanks up to the next tab stop.
// Reset homes the cursor, clears the fault and then sweeps every cell of the
// memory with white blanks with item_stall high. The user must write
// text_color and text_bright over the APB port only while idle; the block
// does not enforce this.
// ----------------------------------------------------------------------------
module text_console_cell_writer import tcw_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LRS   = CELLS - COLUMNS;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int END_W = $clog2(CELLS + TAB_WIDTH + 1);

  logic [COLOR_W-1:0] text_color;
  logic               text_bright;
  logic [CHAR_W-1:0]  attr;
  reg_idx_t           reg_idx;

  state_t             state, state_next;
  logic               boot, boot_next;
  item_t              item_q, item_q_next;
  logic [IDX_W-1:0]   cursor, cursor_next;
  logic               halted, halted_next;
  logic [IDX_W-1:0]   pos, pos_next;
  logic [IDX_W-1:0]   scan, scan_next;
  logic [CNT_W-1:0]   sc, sc_next;
  logic [END_W-1:0]   tab_end, tab_end_next;
  logic [CELL_W-1:0]  value, value_next;
  logic               pend_valid, pend_valid_next;
  logic [IDX_W-1:0]   pend_addr, pend_addr_next;
  logic               pend_blank, pend_blank_next;
  logic               result_valid_next;
  result_t            result_next;

  logic               rem_start;
  logic               col_rem_done;
  logic [IDX_W-1:0]   col_rem;
  logic               tab_rem_done;
  logic [IDX_W-1:0]   tab_rem;

  ram_wr_t            wr;
  ram_rd_t            rd;
  logic [CELL_W-1:0]  rdata;

  assign attr    = {4'b0000, text_bright, text_color};
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color  <= 3'd7;
      text_bright <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_TEXT_COLOR:  text_color  <= pwdata[COLOR_W-1:0];
        REG_TEXT_BRIGHT: text_bright <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEXT_COLOR:  prdata = APB_DATA_W'(text_color);
      REG_TEXT_BRIGHT: prdata = APB_DATA_W'(text_bright);
      default:         prdata = '0;
    endcase
  end

  assign item_stall = (state != ST_IDLE);

  tcw_cell_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  tcw_rem #(
    .DIVIDEND_W (IDX_W),
    .DIVISOR    (COLUMNS)
  ) u_rem_col (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (cursor),
    .done      (col_rem_done),
    .remainder (col_rem)
  );

  tcw_rem #(
    .DIVIDEND_W (IDX_W),
    .DIVISOR    (TAB_WIDTH)
  ) u_rem_tab (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (cursor),
    .done      (tab_rem_done),
    .remainder (tab_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      boot         <= 1'b1;
      sc           <= '0;
      cursor       <= '0;
      halted       <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      boot         <= boot_next;
      sc           <= sc_next;
      cursor       <= cursor_next;
      halted       <= halted_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
    end
    item_q     <= item_q_next;
    pos        <= pos_next;
    scan       <= scan_next;
    tab_end    <= tab_end_next;
    value      <= value_next;
    pend_addr  <= pend_addr_next;
    pend_blank <= pend_blank_next;
    result     <= result_next;
  end

  always_comb begin
    state_next        = state;
    boot_next         = boot;
    item_q_next       = item_q;
    cursor_next       = cursor;
    halted_next       = halted;
    pos_next          = pos;
    scan_next         = scan;
    sc_next           = sc;
    tab_end_next      = tab_end;
    value_next        = value;
    pend_valid_next   = pend_valid;
    pend_addr_next    = pend_addr;
    pend_blank_next   = pend_blank;
    result_valid_next = result_valid && result_stall;
    result_next       = result;
    rem_start         = 1'b0;
    wr                = '0;
    rd                = '0;

    unique case (state)
      ST_CLEAR: begin
        wr.en     = 1'b1;
        wr.addr   = MEM_ADDR_W'(sc[IDX_W-1:0]);
        wr.data   = WHITE_BLANK;
        sc_next   = sc + CNT_W'(1);
        if (sc == CNT_W'(CELLS - 1)) begin
          boot_next  = 1'b0;
          state_next = boot ? ST_IDLE : ST_DONE;
        end
      end

      ST_IDLE: begin
        if (item_valid) begin
          item_q_next = item;
          state_next  = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        value_next = '0;
        state_next = ST_DONE;
        case (item_q.kind)
          KIND_PUT: begin
            if (!halted) begin
              case (item_q.char_code)
                CH_BACKSPACE: begin
                  if (cursor != '0) begin
                    pos_next   = cursor - IDX_W'(1);
                    scan_next  = cursor - IDX_W'(1);
                    wr.en      = 1'b1;
                    wr.addr    = MEM_ADDR_W'(cursor - IDX_W'(1));
                    wr.data    = {attr, BLANK_CHAR};
                    state_next = ST_BS_READ;
                  end
                end
                CH_TAB: begin
                  rem_start  = 1'b1;
                  state_next = ST_REM_WAIT;
                end
                CH_NEWLINE: begin
                  if (32'(cursor) >= LRS) begin
                    cursor_next = IDX_W'(LRS);
                    sc_next     = '0;
                    state_next  = ST_SCROLL;
                  end else begin
                    rem_start  = 1'b1;
                    state_next = ST_REM_WAIT;
                  end
                end
                default: begin
                  wr.en   = 1'b1;
                  wr.addr = MEM_ADDR_W'(cursor);
                  wr.data = {attr, item_q.char_code};
                  if (32'(cursor) == CELLS - 1) begin
                    cursor_next = IDX_W'(LRS);
                    sc_next     = '0;
                    state_next  = ST_SCROLL;
                  end else begin
                    cursor_next = cursor + IDX_W'(1);
                  end
                end
              endcase
            end
          end
          KIND_CLEAR: begin
            cursor_next = '0;
            sc_next     = '0;
            state_next  = ST_CLEAR;
          end
          KIND_READ: begin
            if (32'(item_q.cell_index) < CELLS) begin
              rd.en      = 1'b1;
              rd.addr    = MEM_ADDR_W'(item_q.cell_index);
              state_next = ST_READ_WAIT;
            end
          end
          default: ;
        endcase
      end

      ST_READ_WAIT: begin
        value_next = rdata;
        state_next = ST_DONE;
      end

      ST_BS_READ: begin
        if (scan == '0) begin
          if ((pos - scan) > IDX_W'(1)) begin
            cursor_next = scan;
          end else begin
            cursor_next = pos;
          end
          state_next = ST_DONE;
        end else begin
          rd.en      = 1'b1;
          rd.addr    = MEM_ADDR_W'(scan - IDX_W'(1));
          state_next = ST_BS_CHECK;
        end
      end

      ST_BS_CHECK: begin
        if (rdata[CHAR_W-1:0] == BLANK_CHAR) begin
          scan_next  = scan - IDX_W'(1);
          state_next = ST_BS_READ;
        end else begin
          if ((pos - scan) > IDX_W'(1)) begin
            cursor_next = scan;
          end else begin
            cursor_next = pos;
          end
          state_next = ST_DONE;
        end
      end

      ST_REM_WAIT: begin
        if (item_q.char_code == CH_TAB) begin
          if (tab_rem_done) begin
            tab_end_next = END_W'(cursor) + END_W'(TAB_WIDTH) - END_W'(tab_rem);
            sc_next      = CNT_W'(cursor);
            if (32'(END_W'(cursor) + END_W'(TAB_WIDTH) - END_W'(tab_rem)) >= CELLS) begin
              halted_next = 1'b1;
            end else begin
              cursor_next = IDX_W'(END_W'(cursor) + END_W'(TAB_WIDTH) - END_W'(tab_rem));
            end
            state_next = ST_TAB_FILL;
          end
        end else if (col_rem_done) begin
          cursor_next = cursor - col_rem + IDX_W'(COLUMNS);
          state_next  = ST_DONE;
        end
      end

      ST_TAB_FILL: begin
        if ((END_W'(sc) < tab_end) && (32'(sc) < CELLS)) begin
          wr.en   = 1'b1;
          wr.addr = MEM_ADDR_W'(sc[IDX_W-1:0]);
          wr.data = WHITE_BLANK;
          sc_next = sc + CNT_W'(1);
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_SCROLL: begin
        if (pend_valid) begin
          wr.en   = 1'b1;
          wr.addr = MEM_ADDR_W'(pend_addr);
          wr.data = pend_blank ? WHITE_BLANK : rdata;
        end
        if (32'(sc) < CELLS) begin
          if (32'(sc) < LRS) begin
            rd.en   = 1'b1;
            rd.addr = MEM_ADDR_W'(sc[IDX_W-1:0] + IDX_W'(COLUMNS));
          end
          pend_valid_next = 1'b1;
          pend_addr_next  = sc[IDX_W-1:0];
          pend_blank_next = (32'(sc) >= LRS);
          sc_next         = sc + CNT_W'(1);
        end else begin
          pend_valid_next = 1'b0;
          state_next      = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          result_valid_next      = 1'b1;
          result_next.cursor_pos = INDEX_W'(cursor);
          result_next.cell_value = value;
          result_next.fault      = halted;
          state_next             = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_assert.svh"

module tcw_checker import tcw_pkg::*; #(
  parameter int CELLS = 2000
) (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  logic seen_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_fault <= 1'b0;
    end else if (result_valid && !result_stall && result.fault) begin
      seen_fault <= 1'b1;
    end
  end

  `TCW_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
  `TCW_ASSERT_NXT(a_busy_after_item, item_valid && !item_stall, item_stall)
  `TCW_ASSERT_NOW(a_cursor_range, result_valid, 32'(result.cursor_pos) < CELLS)
  `TCW_ASSERT_NOW(a_fault_sticky, result_valid && seen_fault, result.fault)

endmodule

bind text_console_cell_writer tcw_checker #(.CELLS(COLUMNS * ROWS)) u_tcw_checker (.*);
